// ===== hw/rtl/pdf_pkg.sv =====
// Shared types, constants and CRC helper for the packet deframer.
package pdf_pkg;

    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET      = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd65536;

    localparam logic [3:0]  HDR_ID_END      = 4'd2;
    localparam logic [3:0]  HDR_VER_END     = 4'd4;
    localparam logic [3:0]  HDR_LEN_END     = 4'd8;
    localparam logic [3:0]  HDR_LAST        = 4'd11;

    localparam int          APB_ADDR_W      = 3;
    localparam logic        REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LENGTH = 2'd1,
        ST_CRC    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic        frame_end;
        t_status     status;
        logic [15:0] frame_id;
        logic [15:0] frame_version;
        logic [31:0] frame_length;
    } t_result;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/pdf_if.sv =====
// Request channel interfaces: received bytes in, parsed results out.
interface pdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdf_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic             is_payload;
    logic             frame_end;
    pdf_pkg::t_status status;
    logic [15:0]      frame_id;
    logic [15:0]      frame_version;
    logic [31:0]      frame_length;

    modport source (output valid, output data_byte, output is_payload, output frame_end,
                    output status, output frame_id, output frame_version,
                    output frame_length, input ready);
    modport sink   (input valid, input data_byte, input is_payload, input frame_end,
                    input status, input frame_id, input frame_version,
                    input frame_length, output ready);
endinterface

// ===== hw/rtl/pdf_apb_regs.sv =====
// APB configuration register block: max payload length.
module pdf_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [31:0]                    o_max_payload
);
    logic [31:0] r_max_payload;
    logic        sel_max;

    assign pready  = 1'b1;
    assign sel_max = (paddr[pdf_pkg::APB_ADDR_W-1] == pdf_pkg::REG_MAX_PAYLOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= pdf_pkg::MAX_PAYLOAD_RST;
        end else if (psel && penable && pwrite && pready && sel_max) begin
            r_max_payload <= pwdata;
        end
    end

    assign prdata        = sel_max ? r_max_payload : 32'd0;
    assign o_max_payload = r_max_payload;
endmodule

// ===== hw/rtl/packet_deframer_crc32_check.sv =====
// Top level: length-prefixed frame deframer with CRC-32 check.
//
//  channel  | dir | payload                                  | handshake
//  i_rx     | in  | rx_byte                                  | valid/ready
//  o_res    | out | data_byte, is_payload, frame_end, status, | valid/ready
//           |     | frame_id, frame_version, frame_length    |
//  apb      | in  | max_payload at byte address 0            | psel/penable
//
// One byte per cycle while the output is not stalled; the byte CRC update and
// header parse sit between the frame state registers and the result register.
// A new request is taken whenever the result register is empty or being
// drained, so a stalled output blocks input only when a result is waiting.
// Synchronous active-low reset clears the frame position and result valid and loads the CRC preset.
module packet_deframer_crc32_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pdf_in_if.sink                         i_rx,
    pdf_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pdf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    logic [31:0] max_payload;

    logic [3:0]  r_hdr_idx,    n_hdr_idx;
    logic        r_in_payload, n_in_payload;
    logic [15:0] r_id,         n_id;
    logic [15:0] r_ver,        n_ver;
    logic [31:0] r_len,        n_len;
    logic [31:0] r_chk,        n_chk;
    logic [31:0] r_crc,        n_crc;
    logic [31:0] r_left,       n_left;

    logic             r_out_valid, n_out_valid;
    pdf_pkg::t_result r_out,       n_out;

    logic        accept;
    logic        emit;
    logic [31:0] crc_upd;
    logic [7:0]  b;

    pdf_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (max_payload)
    );

    assign i_rx.ready = i_rst_n && (!r_out_valid || o_res.ready);
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign crc_upd    = pdf_pkg::crc_byte(r_crc, b);

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_in_payload = r_in_payload;
        n_id         = r_id;
        n_ver        = r_ver;
        n_len        = r_len;
        n_chk        = r_chk;
        n_crc        = r_crc;
        n_left       = r_left;
        emit         = 1'b0;
        n_out        = r_out;

        if (accept) begin
            if (r_in_payload) begin
                n_crc                = crc_upd;
                n_left               = r_left - 32'd1;
                emit                 = 1'b1;
                n_out.data_byte      = b;
                n_out.is_payload     = 1'b1;
                n_out.frame_end      = 1'b0;
                n_out.status         = pdf_pkg::ST_OK;
                n_out.frame_id       = r_id;
                n_out.frame_version  = r_ver;
                n_out.frame_length   = r_len;
                if (r_left == 32'd1) begin
                    n_out.frame_end = 1'b1;
                    n_out.status    = ((crc_upd ^ pdf_pkg::CRC_PRESET) == r_chk)
                                      ? pdf_pkg::ST_OK : pdf_pkg::ST_CRC;
                    n_in_payload    = 1'b0;
                    n_hdr_idx       = 4'd0;
                    n_left          = 32'd0;
                    n_crc           = pdf_pkg::CRC_PRESET;
                end
            end else begin
                if (r_hdr_idx < pdf_pkg::HDR_LEN_END) begin
                    n_crc = crc_upd;
                end
                if (r_hdr_idx < pdf_pkg::HDR_ID_END) begin
                    n_id = {r_id[7:0], b};
                end else if (r_hdr_idx < pdf_pkg::HDR_VER_END) begin
                    n_ver = {r_ver[7:0], b};
                end else if (r_hdr_idx < pdf_pkg::HDR_LEN_END) begin
                    n_len = {r_len[23:0], b};
                end else begin
                    n_chk = {r_chk[23:0], b};
                end
                n_hdr_idx = r_hdr_idx + 4'd1;

                if (r_hdr_idx == pdf_pkg::HDR_LAST) begin
                    n_hdr_idx           = 4'd0;
                    n_out.data_byte     = 8'd0;
                    n_out.is_payload    = 1'b0;
                    n_out.frame_end     = 1'b1;
                    n_out.frame_id      = r_id;
                    n_out.frame_version = r_ver;
                    n_out.frame_length  = r_len;
                    n_out.status        = pdf_pkg::ST_OK;
                    if (r_len > max_payload) begin
                        emit         = 1'b1;
                        n_out.status = pdf_pkg::ST_LENGTH;
                        n_crc        = pdf_pkg::CRC_PRESET;
                        n_left       = 32'd0;
                    end else if (r_len == 32'd0) begin
                        emit         = 1'b1;
                        n_out.status = ((r_crc ^ pdf_pkg::CRC_PRESET) == n_chk)
                                       ? pdf_pkg::ST_OK : pdf_pkg::ST_CRC;
                        n_crc        = pdf_pkg::CRC_PRESET;
                        n_left       = 32'd0;
                    end else begin
                        n_in_payload = 1'b1;
                        n_left       = r_len;
                    end
                end
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= 4'd0;
            r_in_payload <= 1'b0;
            r_crc        <= pdf_pkg::CRC_PRESET;
            r_left       <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hdr_idx    <= n_hdr_idx;
            r_in_payload <= n_in_payload;
            r_crc        <= n_crc;
            r_left       <= n_left;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_ver <= n_ver;
        r_len <= n_len;
        r_chk <= n_chk;
        r_out <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.data_byte     = r_out.data_byte;
    assign o_res.is_payload    = r_out.is_payload;
    assign o_res.frame_end     = r_out.frame_end;
    assign o_res.status        = r_out.status;
    assign o_res.frame_id      = r_out.frame_id;
    assign o_res.frame_version = r_out.frame_version;
    assign o_res.frame_length  = r_out.frame_length;
endmodule

// ===== hw/rtl/pdf_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
module pdf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_is_payload,
    input logic        i_frame_end,
    input logic [31:0] i_frame_length
);
    // a result only appears after an input request
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without input request");

    // a waiting result blocks input
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while result stalled");

    // a result without payload always closes the frame
    a_header_result_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_is_payload) |-> i_frame_end)
        else $error("non-payload result without frame end");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_frame_end)
                                           && $stable(i_frame_length)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind packet_deframer_crc32_check pdf_checker u_pdf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_is_payload   (o_res.is_payload),
    .i_frame_end    (o_res.frame_end),
    .i_frame_length (o_res.frame_length)
);
